// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the synthesizer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define HWS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// An implication checked in the same cycle outside reset.
`define HWS_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== hdl/hws_pkg.sv =====
// Shared types and constants of the harmonic waveform synthesizer.
package hws_pkg;

   localparam int HWS_HARMONICS  = 10;
   localparam int HWS_SINE_DEPTH = 1024;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  harmonic_number;
      logic [30:0] amplitude;
      logic [15:0] phase_turns;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic [7:0]         sample_index;
   } rsp_word_type;

   typedef struct packed {
      logic load;
      logic start_sample;
      logic issue;
      logic finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_issue;
      logic acc_done;
      logic pipe_active;
   } ctl_status_type;

endpackage

// ===== hdl/harmonic_waveform_synth.sv =====
// Top level of the harmonic waveform synthesizer.
//
//   Channel   Ports                          Handshake
//   request   start, busy, req_data          taken when start is high and busy is low
//   result    rsp_valid, rsp_data            one-cycle strobe, cannot be held off
//   config    csr_wr_en, csr_wr_data         written on any edge with csr_wr_en high
//
// A load word (cmd 0) leaves busy low. A sample word holds busy high through
// one issue per harmonic, the drain of the last product through the sine
// pipeline and the finish state. Its strobe comes in the first cycle with
// busy low again, when the next word can already be taken; a new sample
// word is taken only once the last has finished. Reset is synchronous and
// clears control and stored state, not the payload; results cannot be stalled.
//
// The controller sequences each sample request through issue, drain and
// finish; the datapath holds the harmonic amplitude and phase stores, the two
// wrapping period indexes, the folded quarter-wave sine evaluation in Q30, and
// the accumulator that divides its total toward zero and saturates it to a
// 32-bit word.

module harmonic_waveform_synth
   import hws_pkg::*;
#(
   parameter int HARMONIC_COUNT   = HWS_HARMONICS,
   parameter int SINE_TABLE_DEPTH = HWS_SINE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_data,
   output logic         rsp_valid,
   output rsp_word_type rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);

   ctl_cmd_type    ctl_cmd;
   ctl_status_type ctl_status;

   // The controller only looks at the command bit of the request word; the
   // rest of the word goes straight into the datapath, which acts on it at
   // the accepting edge.
   hws_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req_cmd (req_data.cmd),
      .busy    (busy),
      .cmd     (ctl_cmd),
      .status  (ctl_status)
   );

   hws_datapath #(
      .HARMONIC_COUNT   (HARMONIC_COUNT),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (ctl_cmd),
      .status      (ctl_status),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== hdl/hws_ctrl.sv =====
// Sequencer that steps one sample request through issue, drain and finish.
`include "assert_macros.svh"

module hws_ctrl
   import hws_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           req_cmd,
   output logic           busy,
   output ctl_cmd_type    cmd,
   input  ctl_status_type status
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_ISSUE  = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_SAMPLE) begin
                  cmd.start_sample = 1'b1;
                  state_in         = ST_ISSUE;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.acc_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // The last product must reach the accumulator only once issuing is over.
   `HWS_ASSERT_IMPLY(a_done_in_drain, clock, reset, status.acc_done, state_ff == ST_DRAIN, "accumulation finished outside drain")
   `HWS_ASSERT_IMPLY(a_idle_empty, clock, reset, state_ff == ST_IDLE, !status.pipe_active, "pipeline busy while idle")
   `HWS_ASSERT_IMPLY(a_finish_empty, clock, reset, state_ff == ST_FINISH, !status.pipe_active, "pipeline busy at finish")

endmodule

// ===== hdl/hws_datapath.sv =====
// Harmonic stores, period indexes, pipelined sine evaluation and accumulator.
`include "assert_macros.svh"

module hws_datapath
   import hws_pkg::*;
#(
   parameter int HARMONIC_COUNT   = HWS_HARMONICS,
   parameter int SINE_TABLE_DEPTH = HWS_SINE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  ctl_cmd_type    cmd,
   output ctl_status_type status,
   input  req_word_type   req_data,
   input  logic           csr_wr_en,
   input  logic           csr_wr_data,
   output logic           rsp_valid,
   output rsp_word_type   rsp_data
);

   localparam int HIDX_W = (HARMONIC_COUNT > 1) ? $clog2(HARMONIC_COUNT) : 1;
   localparam logic [HIDX_W-1:0] LAST_H = HIDX_W'(HARMONIC_COUNT - 1);
   localparam int LOG2D  = $clog2(SINE_TABLE_DEPTH);
   localparam int ACC_W  = 48 + $clog2(HARMONIC_COUNT);
   localparam int NSTG   = 9;

   localparam logic [8:0]  SHORT_N = 9'd80;
   localparam logic [8:0]  LONG_N  = 9'd256;
   localparam logic [6:0]  SHORT_LAST = 7'd79;
   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [30:0] C1 = 31'd1686629713;
   localparam logic [30:0] C3 = 31'd693598666;
   localparam logic [30:0] C5 = 31'd85569306;
   localparam logic [30:0] C7 = 31'd5026996;
   localparam logic [30:0] C9 = 31'd172272;

   // Q30 product, truncated; the second operand may exceed one, as C1 and s1 do.
   function automatic logic [30:0] mul_q30(input logic [30:0] a, input logic [30:0] b);
      logic [61:0] prod;
      prod = 62'(a) * 62'(b);
      return prod[60:30];
   endfunction

   // Configuration and stored state
   logic              mode_ff;
   logic [30:0]       amp_ff   [HARMONIC_COUNT];
   logic [15:0]       phase_ff [HARMONIC_COUNT];
   logic [6:0]        idx_short_ff;
   logic [7:0]        idx_long_ff;

   // Per-sample control
   logic              long_ff;
   logic              long_in;
   logic [7:0]        cur_idx_ff;
   logic [7:0]        cur_idx_in;
   logic [HIDX_W-1:0] hcnt_ff;
   logic [HIDX_W-1:0] hcnt_in;
   logic [7:0]        base_ff;
   logic [7:0]        base_in;

   // Pipeline
   logic              vld_ff      [1:NSTG];
   logic              vld_in      [1:NSTG];
   logic              last_ff     [1:NSTG];
   logic              last_in     [1:NSTG];
   logic [30:0]       x_pipe_ff   [1:6];
   logic [30:0]       x_pipe_in   [1:6];
   logic [30:0]       x2_pipe_ff  [2:5];
   logic [30:0]       x2_pipe_in  [2:5];
   logic [30:0]       amp_pipe_ff [1:8];
   logic [30:0]       amp_pipe_in [1:8];
   logic              neg_pipe_ff [1:8];
   logic              neg_pipe_in [1:8];
   logic [30:0]       s7_ff, s7_in;
   logic [30:0]       s5_ff, s5_in;
   logic [30:0]       s3_ff, s3_in;
   logic [30:0]       s1_ff, s1_in;
   logic [30:0]       y_ff, y_in;
   logic signed [15:0] sine_ff, sine_in;
   logic signed [47:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Output
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   rsp_word_type      rsp_data_ff;
   rsp_word_type      rsp_data_in;

   // Combinational helpers
   logic [7:0]        i_sel;
   logic [8:0]        n_sel;
   logic [8:0]        base_sum;
   logic [7:0]        base_next;
   logic [17:0]       mul819;
   logic [17:0]       div5;
   logic [15:0]       angle;
   logic [15:0]       p_turn;
   logic [LOG2D-1:0]  j_idx;
   logic [30:0]       x_lin;
   logic [30:0]       x_new;
   logic [46:0]       v_round;
   logic [16:0]       v_wide;
   logic [14:0]       v_mag;
   logic signed [ACC_W-1:0] acc_bias;
   logic signed [ACC_W-1:0] quot;
   logic [ACC_W-32:0] quot_top;
   logic              pipe_any;

   assign i_sel = mode_ff ? idx_long_ff : {1'b0, idx_short_ff};
   assign n_sel = long_ff ? LONG_N : SHORT_N;

   // Next multiple of the index, reduced modulo the period length.
   assign base_sum  = 9'(base_ff) + 9'(cur_idx_ff);
   assign base_next = (base_sum >= n_sel) ? 8'(base_sum - n_sel) : base_sum[7:0];

   // base*65536/80 equals base*819 plus base/5; base/5 is exact as base*205 >> 10.
   assign mul819 = 18'(base_ff) * 18'd819;
   assign div5   = (18'(base_ff) * 18'd205) >> 10;
   assign angle  = long_ff ? {base_ff, 8'h00} : 16'(mul819 + div5);
   assign p_turn = angle + phase_ff[hcnt_ff];

   // Quarter-wave folding of the quantized angle.
   assign j_idx = p_turn[15 -: LOG2D];
   assign x_lin = 31'(j_idx[LOG2D-3:0]) << (32 - LOG2D);
   assign x_new = j_idx[LOG2D-2] ? (Q30_ONE - x_lin) : x_lin;

   // Q1.15 rounding of the polynomial result.
   assign v_round = 47'({y_ff, 15'h0000}) - 47'(y_ff) + 47'(32'h2000_0000);
   assign v_wide  = v_round[46:30];
   assign v_mag   = (v_wide > 17'd32767) ? 15'h7fff : v_wide[14:0];

   // Division by 32768 toward zero, then saturation.
   assign acc_bias = acc_ff[ACC_W-1] ? (acc_ff + ACC_W'(32767)) : acc_ff;
   assign quot     = acc_bias >>> 15;
   assign quot_top = quot[ACC_W-1:31];

   always_comb begin
      long_in    = long_ff;
      cur_idx_in = cur_idx_ff;
      hcnt_in    = hcnt_ff;
      base_in    = base_ff;
      if (cmd.start_sample) begin
         long_in    = mode_ff;
         cur_idx_in = i_sel;
         hcnt_in    = '0;
         base_in    = i_sel;
      end else if (cmd.issue) begin
         hcnt_in = (hcnt_ff == LAST_H) ? '0 : hcnt_ff + 1'b1;
         base_in = base_next;
      end
   end

   always_comb begin
      vld_in[1]      = cmd.issue;
      last_in[1]     = cmd.issue && (hcnt_ff == LAST_H);
      x_pipe_in[1]   = x_new;
      amp_pipe_in[1] = amp_ff[hcnt_ff];
      neg_pipe_in[1] = j_idx[LOG2D-1];
      for (int st = 2; st <= NSTG; st++) begin
         vld_in[st]  = vld_ff[st-1];
         last_in[st] = last_ff[st-1];
      end
      for (int st = 2; st <= 6; st++) begin
         x_pipe_in[st] = x_pipe_ff[st-1];
      end
      for (int st = 2; st <= 8; st++) begin
         amp_pipe_in[st] = amp_pipe_ff[st-1];
         neg_pipe_in[st] = neg_pipe_ff[st-1];
      end
      x2_pipe_in[2] = mul_q30(x_pipe_ff[1], x_pipe_ff[1]);
      for (int st = 3; st <= 5; st++) begin
         x2_pipe_in[st] = x2_pipe_ff[st-1];
      end
      s7_in   = C7 - mul_q30(x2_pipe_ff[2], C9);
      s5_in   = C5 - mul_q30(x2_pipe_ff[3], s7_ff);
      s3_in   = C3 - mul_q30(x2_pipe_ff[4], s5_ff);
      s1_in   = C1 - mul_q30(x2_pipe_ff[5], s3_ff);
      y_in    = mul_q30(x_pipe_ff[6], s1_ff);
      sine_in = neg_pipe_ff[7] ? -$signed({1'b0, v_mag}) : $signed({1'b0, v_mag});
      prod_in = 48'($signed({1'b0, amp_pipe_ff[8]})) * 48'(sine_ff);
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.start_sample) begin
         acc_in = '0;
      end else if (vld_ff[NSTG]) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_comb begin
      rsp_valid_in = cmd.finish;
      rsp_data_in  = rsp_data_ff;
      if (cmd.finish) begin
         rsp_data_in.sample_index = cur_idx_ff;
         if ((&quot_top) || !(|quot_top)) begin
            rsp_data_in.sample = quot[31:0];
         end else if (quot[ACC_W-1]) begin
            rsp_data_in.sample = 32'sh8000_0000;
         end else begin
            rsp_data_in.sample = 32'sh7fff_ffff;
         end
      end
   end

   // Stored state with reset values
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         idx_short_ff <= '0;
         idx_long_ff  <= '0;
         for (int h = 0; h < HARMONIC_COUNT; h++) begin
            amp_ff[h]   <= '0;
            phase_ff[h] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            mode_ff <= csr_wr_data;
         end
         if (cmd.load && (int'(req_data.harmonic_number) < HARMONIC_COUNT)) begin
            amp_ff[req_data.harmonic_number[HIDX_W-1:0]]   <= req_data.amplitude;
            phase_ff[req_data.harmonic_number[HIDX_W-1:0]] <= req_data.phase_turns;
         end
         if (cmd.start_sample) begin
            if (mode_ff) begin
               idx_long_ff <= idx_long_ff + 8'd1;
            end else begin
               idx_short_ff <= (idx_short_ff == SHORT_LAST) ? '0 : idx_short_ff + 7'd1;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         hcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int st = 1; st <= NSTG; st++) begin
            vld_ff[st]  <= 1'b0;
            last_ff[st] <= 1'b0;
         end
      end else begin
         hcnt_ff      <= hcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int st = 1; st <= NSTG; st++) begin
            vld_ff[st]  <= vld_in[st];
            last_ff[st] <= last_in[st];
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      long_ff     <= long_in;
      cur_idx_ff  <= cur_idx_in;
      base_ff     <= base_in;
      s7_ff       <= s7_in;
      s5_ff       <= s5_in;
      s3_ff       <= s3_in;
      s1_ff       <= s1_in;
      y_ff        <= y_in;
      sine_ff     <= sine_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      for (int st = 1; st <= 6; st++) begin
         x_pipe_ff[st] <= x_pipe_in[st];
      end
      for (int st = 2; st <= 5; st++) begin
         x2_pipe_ff[st] <= x2_pipe_in[st];
      end
      for (int st = 1; st <= 8; st++) begin
         amp_pipe_ff[st] <= amp_pipe_in[st];
         neg_pipe_ff[st] <= neg_pipe_in[st];
      end
   end

   always_comb begin
      pipe_any = 1'b0;
      for (int st = 1; st <= NSTG; st++) begin
         pipe_any = pipe_any | vld_ff[st];
      end
   end

   assign status.last_issue  = (hcnt_ff == LAST_H);
   assign status.acc_done    = vld_ff[NSTG] && last_ff[NSTG];
   assign status.pipe_active = pipe_any;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `HWS_ASSERT_IMPLY(a_rsp_pipe_empty, clock, reset, rsp_valid_ff, !pipe_any, "result shown while pipeline busy")
   `HWS_ASSERT(a_short_index_range, clock, reset, 9'(idx_short_ff) < SHORT_N, "short period index out of range")
   `HWS_ASSERT_IMPLY(a_base_range, clock, reset, cmd.issue, 9'(base_ff) < n_sel, "harmonic angle base out of range")

endmodule
